### rtl/rballoc_pkg.sv
// Package with the shared constants, codes and structs of the ring bridge allocator.
package rballoc_pkg;

  // Field widths of the channel payloads.
  localparam int TAG_W   = 16;
  localparam int BYTES_W = 9;
  localparam int WIDTH_W = 7;
  localparam int GRANT_W = 2;

  // Packet limits.
  localparam int MAX_PACKET_BYTES = 256;
  localparam int TAG_BITS         = 16;

  // Tag bits kept: the tag field, narrowed further when TAG_BITS is smaller.
  localparam logic [TAG_W-1:0] TAG_MASK = (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} :
                                          TAG_W'((64'd1 << TAG_BITS) - 64'd1);

  // Clamped packet length as a field-wide constant.
  localparam logic [BYTES_W-1:0] MAX_BYTES_VAL = BYTES_W'(MAX_PACKET_BYTES);

  // Reset value of the serializer width register.
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(32);

  // Grant codes.
  localparam logic [GRANT_W-1:0] GRANT_NONE = 2'd0;
  localparam logic [GRANT_W-1:0] GRANT_CW   = 2'd1;
  localparam logic [GRANT_W-1:0] GRANT_CCW  = 2'd2;

  // Output directions, used as serializer index and preferred direction.
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // One input queue head.
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
    logic [1:0]         pref;
  } head_t;

  // One allocation tick as captured from the input channel.
  typedef struct packed {
    head_t cw;
    head_t ccw;
    logic  cw_space;
    logic  ccw_space;
  } tick_t;

  // Packet handed to a serializer on a grant.
  typedef struct packed {
    logic               load;
    logic [BYTES_W-1:0] bytes;
    logic [TAG_W-1:0]   tag;
  } load_t;

  // Serializer status for the current tick.
  typedef struct packed {
    logic             handoff_valid;
    logic [TAG_W-1:0] handoff_tag;
    logic             idle;
  } ser_status_t;

  // Allocation decision for the current tick.
  typedef struct packed {
    logic [GRANT_W-1:0] cw_grant;
    logic [GRANT_W-1:0] ccw_grant;
    logic               favored;
  } decision_t;

  // Complete result of one tick.
  typedef struct packed {
    decision_t   dec;
    ser_status_t cw;
    ser_status_t ccw;
  } result_t;

endpackage

### rtl/rballoc_if.sv
// Channel interfaces of the ring bridge allocator: tick input, allocation result, configuration.
interface rballoc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cw_head_valid;
  logic [rballoc_pkg::TAG_W-1:0]       cw_head_tag;
  logic [rballoc_pkg::BYTES_W-1:0]     cw_head_bytes;
  logic [1:0]                          cw_head_pref;
  logic                                ccw_head_valid;
  logic [rballoc_pkg::TAG_W-1:0]       ccw_head_tag;
  logic [rballoc_pkg::BYTES_W-1:0]     ccw_head_bytes;
  logic [1:0]                          ccw_head_pref;
  logic                                cw_out_space;
  logic                                ccw_out_space;

  modport source (
    output valid, cw_head_valid, cw_head_tag, cw_head_bytes, cw_head_pref,
           ccw_head_valid, ccw_head_tag, ccw_head_bytes, ccw_head_pref,
           cw_out_space, ccw_out_space,
    input  ready
  );
  modport sink (
    input  valid, cw_head_valid, cw_head_tag, cw_head_bytes, cw_head_pref,
           ccw_head_valid, ccw_head_tag, ccw_head_bytes, ccw_head_pref,
           cw_out_space, ccw_out_space,
    output ready
  );
endinterface

interface rballoc_out_if;
  logic                                valid;
  logic                                ready;
  logic [rballoc_pkg::GRANT_W-1:0]     cw_head_grant;
  logic [rballoc_pkg::GRANT_W-1:0]     ccw_head_grant;
  logic                                cw_handoff_valid;
  logic [rballoc_pkg::TAG_W-1:0]       cw_handoff_tag;
  logic                                ccw_handoff_valid;
  logic [rballoc_pkg::TAG_W-1:0]       ccw_handoff_tag;
  logic                                cw_out_idle;
  logic                                ccw_out_idle;
  logic                                round_robin_input;

  modport source (
    output valid, cw_head_grant, ccw_head_grant, cw_handoff_valid, cw_handoff_tag,
           ccw_handoff_valid, ccw_handoff_tag, cw_out_idle, ccw_out_idle,
           round_robin_input,
    input  ready
  );
  modport sink (
    input  valid, cw_head_grant, ccw_head_grant, cw_handoff_valid, cw_handoff_tag,
           ccw_handoff_valid, ccw_handoff_tag, cw_out_idle, ccw_out_idle,
           round_robin_input,
    output ready
  );
endinterface

interface rballoc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rballoc_pkg::WIDTH_W-1:0]     bytes_per_tick;

  modport source (output valid, bytes_per_tick, input ready);
  modport sink (input valid, bytes_per_tick, output ready);
endinterface

### rtl/rballoc_arbiter.sv
// Two-by-two allocation: picks the best assignment of heads to outputs and keeps the policy pointers.
module rballoc_arbiter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  rballoc_pkg::tick_t     tick,
  input  logic [1:0]             busy,
  output rballoc_pkg::decision_t dec,
  output rballoc_pkg::load_t     load_cw,
  output rballoc_pkg::load_t     load_ccw
);

  // Policy pointers.
  logic favored_input;
  logic favored_input_next;
  logic tie_direction;
  logic tie_direction_next;

  logic [1:0] head_valid;
  logic [1:0] head_tie;
  logic [1:0] pref_dir;
  logic [1:0] avail;
  logic [rballoc_pkg::GRANT_W-1:0] best_g0;
  logic [rballoc_pkg::GRANT_W-1:0] best_g1;
  logic [rballoc_pkg::BYTES_W-1:0] cw_bytes;
  logic [rballoc_pkg::BYTES_W-1:0] ccw_bytes;
  logic [rballoc_pkg::TAG_W-1:0]   cw_tag;
  logic [rballoc_pkg::TAG_W-1:0]   ccw_tag;

  // Head decode: ties resolve to the tie pointer, outputs need space and an idle serializer.
  always_comb begin
    head_valid = {tick.ccw.valid, tick.cw.valid};
    head_tie   = {tick.ccw.pref[1], tick.cw.pref[1]};
    pref_dir[0] = head_tie[0] ? tie_direction : tick.cw.pref[0];
    pref_dir[1] = head_tie[1] ? tie_direction : tick.ccw.pref[0];
    avail[0] = !busy[0] && tick.cw_space;
    avail[1] = !busy[1] && tick.ccw_space;
  end

  // Packet length clamp and tag mask.
  always_comb begin
    cw_bytes  = (32'(tick.cw.bytes) > rballoc_pkg::MAX_PACKET_BYTES) ?
                rballoc_pkg::MAX_BYTES_VAL : tick.cw.bytes;
    ccw_bytes = (32'(tick.ccw.bytes) > rballoc_pkg::MAX_PACKET_BYTES) ?
                rballoc_pkg::MAX_BYTES_VAL : tick.ccw.bytes;
    cw_tag    = tick.cw.tag & rballoc_pkg::TAG_MASK;
    ccw_tag   = tick.ccw.tag & rballoc_pkg::TAG_MASK;
  end

  // Scan the nine assignments; the first one with the highest key wins.
  // Key order: transfers, preferred transfers, favored input served, clockwise served.
  always_comb begin
    logic       legal;
    logic [1:0] xfer;
    logic [1:0] pr;
    logic       t_next;
    logic       t_cw;
    logic [5:0] cand_key;
    logic [5:0] best_key;
    best_key = '0;
    best_g0  = rballoc_pkg::GRANT_NONE;
    best_g1  = rballoc_pkg::GRANT_NONE;
    for (int ga = 0; ga < 3; ga++) begin
      for (int gb = 0; gb < 3; gb++) begin
        legal = 1'b1;
        xfer  = 2'd0;
        pr    = 2'd0;
        if (ga != 0) begin
          if (!head_valid[0] || !avail[ga-1]) begin
            legal = 1'b0;
          end
          xfer = xfer + 2'd1;
          if (pref_dir[0] == (ga == 2)) begin
            pr = pr + 2'd1;
          end
        end
        if (gb != 0) begin
          if (!head_valid[1] || gb == ga || !avail[gb-1]) begin
            legal = 1'b0;
          end
          xfer = xfer + 2'd1;
          if (pref_dir[1] == (gb == 2)) begin
            pr = pr + 2'd1;
          end
        end
        t_next   = favored_input ? (gb != 0) : (ga != 0);
        t_cw     = (ga != 0);
        cand_key = {xfer, pr, t_next, t_cw};
        if (legal && cand_key > best_key) begin
          best_key = cand_key;
          best_g0  = rballoc_pkg::GRANT_W'(ga);
          best_g1  = rballoc_pkg::GRANT_W'(gb);
        end
      end
    end
  end

  // Pointer updates for this tick.
  always_comb begin
    logic any_grant;
    any_grant = (best_g0 != rballoc_pkg::GRANT_NONE) || (best_g1 != rballoc_pkg::GRANT_NONE);
    tie_direction_next = tie_direction
                       ^ ((best_g0 != rballoc_pkg::GRANT_NONE) && head_tie[0])
                       ^ ((best_g1 != rballoc_pkg::GRANT_NONE) && head_tie[1]);
    favored_input_next = favored_input
                       ^ (any_grant && head_valid[0] && head_valid[1]
                          && (pref_dir[0] == pref_dir[1]));
  end

  // Serializer loads: each output takes the head granted to it.
  always_comb begin
    load_cw  = '0;
    load_ccw = '0;
    if (best_g0 == rballoc_pkg::GRANT_CW) begin
      load_cw = '{load: 1'b1, bytes: cw_bytes, tag: cw_tag};
    end else if (best_g1 == rballoc_pkg::GRANT_CW) begin
      load_cw = '{load: 1'b1, bytes: ccw_bytes, tag: ccw_tag};
    end
    if (best_g0 == rballoc_pkg::GRANT_CCW) begin
      load_ccw = '{load: 1'b1, bytes: cw_bytes, tag: cw_tag};
    end else if (best_g1 == rballoc_pkg::GRANT_CCW) begin
      load_ccw = '{load: 1'b1, bytes: ccw_bytes, tag: ccw_tag};
    end
  end

  assign dec = '{cw_grant: best_g0, ccw_grant: best_g1, favored: favored_input_next};

  // Pointer registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      favored_input <= rballoc_pkg::DIR_CW;
      tie_direction <= rballoc_pkg::DIR_CW;
    end else if (advance) begin
      favored_input <= favored_input_next;
      tie_direction <= tie_direction_next;
    end
  end

endmodule

### rtl/rballoc_serializer.sv
// One output serializer: holds a granted packet and counts its bytes down by the width each tick.
module rballoc_serializer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [rballoc_pkg::WIDTH_W-1:0]   bytes_per_tick,
  input  rballoc_pkg::load_t                load,
  output logic                              busy,
  output rballoc_pkg::ser_status_t          status
);

  logic [rballoc_pkg::BYTES_W-1:0] remaining;
  logic [rballoc_pkg::BYTES_W-1:0] remaining_next;
  logic [rballoc_pkg::TAG_W-1:0]   held_tag;
  logic [rballoc_pkg::TAG_W-1:0]   held_tag_next;
  logic                            pending;
  logic                            pending_next;

  // A grant loads the packet first; the same tick then moves one width of it.
  always_comb begin
    logic [rballoc_pkg::WIDTH_W-1:0] w;
    logic                            last;
    w = (bytes_per_tick == '0) ? rballoc_pkg::WIDTH_W'(1) : bytes_per_tick;
    pending_next   = load.load | pending;
    remaining_next = load.load ? load.bytes : remaining;
    held_tag_next  = load.load ? load.tag : held_tag;
    last = pending_next && (remaining_next <= rballoc_pkg::BYTES_W'(w));
    status.handoff_valid = last;
    status.handoff_tag   = last ? held_tag_next : '0;
    if (last) begin
      remaining_next = '0;
      pending_next   = 1'b0;
    end else if (pending_next) begin
      remaining_next = remaining_next - rballoc_pkg::BYTES_W'(w);
    end
    status.idle = !pending_next;
  end

  assign busy = pending;

  // Control state resets; the tag register holds payload only.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      remaining <= '0;
    end else if (advance) begin
      pending   <= pending_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_tag <= held_tag_next;
    end
  end

endmodule

### rtl/ring_bridge_two_by_two_allocator.sv
// Top level of the ring bridge two-by-two allocator for one bridge path.
//
//   channel  modport  carries
//   tick     sink     queue heads and destination space for one tick
//   alloc    source   grants, handoffs, serializer idle flags, round-robin input
//   cfg      sink     serializer width in bytes per tick
//
// Each item passes an input register and then a result register, from which its result is
// offered; one item is accepted per cycle while the result register is empty or drains.
// The allocation scan and the serializer countdown sit between those two registers,
// and the state they update is written as the item moves into the result register.
// A stalled result holds; the input register takes an item while the result waits only if it is empty.
// Reset is synchronous and clears both pipeline stages, the pointers and the serializers.
module ring_bridge_two_by_two_allocator (
  input  logic           clk,
  input  logic           rst,
  rballoc_in_if.sink     tick,
  rballoc_out_if.source  alloc,
  rballoc_cfg_if.sink    cfg
);

  logic                            in_valid;
  rballoc_pkg::tick_t              in_item;
  logic                            res_valid;
  rballoc_pkg::result_t            res_item;
  logic                            advance;
  logic [rballoc_pkg::WIDTH_W-1:0] bytes_per_tick;
  logic [1:0]                      busy;
  rballoc_pkg::decision_t          dec;
  rballoc_pkg::load_t              load_cw;
  rballoc_pkg::load_t              load_ccw;
  rballoc_pkg::ser_status_t        cw_status;
  rballoc_pkg::ser_status_t        ccw_status;

  // Pipeline handshake: an item moves on when the result register is empty or drains.
  assign advance    = in_valid && (!res_valid || alloc.ready);
  assign tick.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  // Width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_tick <= rballoc_pkg::WIDTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      bytes_per_tick <= cfg.bytes_per_tick;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_item.cw.valid  <= tick.cw_head_valid;
      in_item.cw.tag    <= tick.cw_head_tag;
      in_item.cw.bytes  <= tick.cw_head_bytes;
      in_item.cw.pref   <= tick.cw_head_pref;
      in_item.ccw.valid <= tick.ccw_head_valid;
      in_item.ccw.tag   <= tick.ccw_head_tag;
      in_item.ccw.bytes <= tick.ccw_head_bytes;
      in_item.ccw.pref  <= tick.ccw_head_pref;
      in_item.cw_space  <= tick.cw_out_space;
      in_item.ccw_space <= tick.ccw_out_space;
    end
  end

  // Allocation and pointer state.
  rballoc_arbiter u_arbiter (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .tick     (in_item),
    .busy     (busy),
    .dec      (dec),
    .load_cw  (load_cw),
    .load_ccw (load_ccw)
  );

  // Output serializers.
  rballoc_serializer u_ser_cw (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .bytes_per_tick (bytes_per_tick),
    .load           (load_cw),
    .busy           (busy[0]),
    .status         (cw_status)
  );

  rballoc_serializer u_ser_ccw (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .bytes_per_tick (bytes_per_tick),
    .load           (load_ccw),
    .busy           (busy[1]),
    .status         (ccw_status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (alloc.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= '{dec: dec, cw: cw_status, ccw: ccw_status};
    end
  end

  // Result channel.
  assign alloc.valid             = res_valid;
  assign alloc.cw_head_grant     = res_item.dec.cw_grant;
  assign alloc.ccw_head_grant    = res_item.dec.ccw_grant;
  assign alloc.cw_handoff_valid  = res_item.cw.handoff_valid;
  assign alloc.cw_handoff_tag    = res_item.cw.handoff_tag;
  assign alloc.ccw_handoff_valid = res_item.ccw.handoff_valid;
  assign alloc.ccw_handoff_tag   = res_item.ccw.handoff_tag;
  assign alloc.cw_out_idle       = res_item.cw.idle;
  assign alloc.ccw_out_idle      = res_item.ccw.idle;
  assign alloc.round_robin_input = res_item.dec.favored;

endmodule

### test/tb.sv
// Self-checking testbench for the ring bridge two-by-two allocator with its own prediction.
`timescale 1ns / 1ps

module tb;

  // Preference codes carried by a queue head.
  localparam logic [1:0] PREF_CW      = 2'd0;
  localparam logic [1:0] PREF_CCW     = 2'd1;
  localparam logic [1:0] PREF_TIE     = 2'd2;
  localparam logic [1:0] PREF_TIE_ALT = 2'd3;

  // Output index used for a head that is given no output.
  localparam int NO_OUT = -1;

  // Run limits in clock cycles.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rballoc_in_if  tick_if ();
  rballoc_out_if alloc_if ();
  rballoc_cfg_if cfg_if ();

  ring_bridge_two_by_two_allocator DUT (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_if),
    .alloc (alloc_if),
    .cfg   (cfg_if)
  );

  // Ticks waiting to be driven and allocation results waiting to be seen.
  rballoc_pkg::tick_t   tick_queue [$];
  rballoc_pkg::result_t expected_allocs [$];
  rballoc_pkg::tick_t   drive_tick;
  logic                 tick_taken;

  // Idle percentages of the sender and the receiver.
  int send_idle_pct = 16;
  int recv_idle_pct = 83;

  // Predicted allocator state.
  logic [rballoc_pkg::WIDTH_W-1:0] width_reg;
  int                              ser_left [2];
  logic [rballoc_pkg::TAG_W-1:0]   ser_tag  [2];
  logic                            ser_busy [2];
  logic                            favored;
  logic                            tie_dir;

  // Run bookkeeping.
  int cycle_count = 0;
  int fail_count = 0;
  int ticks_taken = 0;
  int results_checked = 0;
  int grant_count = 0;
  int handoff_count = 0;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [rballoc_pkg::GRANT_W-1:0] grant_code(int o);
    if (o == NO_OUT) begin
      return rballoc_pkg::GRANT_NONE;
    end
    return (o == 0) ? rballoc_pkg::GRANT_CW : rballoc_pkg::GRANT_CCW;
  endfunction

  // Allocate one tick: pick the best of the nine assignments, load the
  // serializers, then count down and hand off finished packets.
  function automatic rballoc_pkg::result_t predict_tick(rballoc_pkg::tick_t t);
    rballoc_pkg::head_t hd [2];
    logic    space [2];
    int      len [2];
    logic    tie [2];
    logic    pref [2];
    logic    avail [2];
    int      best [2];
    int      trial [2];
    int      best_xfer, best_pref, xfer, pr, step, a, b, i, o;
    logic    have, ok, t_fav, b_fav, t_cw, b_cw;
    logic    hv [2];
    logic [rballoc_pkg::TAG_W-1:0] htag [2];
    rballoc_pkg::result_t r;

    hd[0] = t.cw;
    hd[1] = t.ccw;
    space[0] = t.cw_space;
    space[1] = t.ccw_space;
    step = (width_reg == 0) ? 1 : int'(width_reg);
    for (i = 0; i < 2; i++) begin
      len[i] = (hd[i].bytes > rballoc_pkg::MAX_PACKET_BYTES) ? rballoc_pkg::MAX_PACKET_BYTES :
               int'(hd[i].bytes);
      tie[i] = hd[i].pref >= PREF_TIE;
      pref[i] = tie[i] ? tie_dir : hd[i].pref[0];
      avail[i] = !ser_busy[i] && space[i];
    end

    // Scan the clockwise head's choice outside, the other head's inside.
    best[0] = NO_OUT;
    best[1] = NO_OUT;
    have = 1'b0;
    best_xfer = 0;
    best_pref = 0;
    for (a = NO_OUT; a <= 1; a++) begin
      for (b = NO_OUT; b <= 1; b++) begin
        trial[0] = a;
        trial[1] = b;
        xfer = 0;
        pr = 0;
        ok = 1'b1;
        for (i = 0; i < 2; i++) begin
          if (ok && trial[i] != NO_OUT) begin
            if (!hd[i].valid || (i == 1 && trial[1] == trial[0]) || !avail[trial[i]]) begin
              ok = 1'b0;
            end else begin
              xfer++;
              if (int'(pref[i]) == trial[i]) pr++;
            end
          end
        end
        if (ok) begin
          t_fav = trial[favored] != NO_OUT;
          b_fav = have && best[favored] != NO_OUT;
          t_cw = trial[0] != NO_OUT;
          b_cw = have && best[0] != NO_OUT;
          if (!have || xfer > best_xfer ||
              (xfer == best_xfer && pr > best_pref) ||
              (xfer == best_xfer && pr == best_pref && t_fav && !b_fav) ||
              (xfer == best_xfer && pr == best_pref && t_fav == b_fav && t_cw && !b_cw)) begin
            best[0] = trial[0];
            best[1] = trial[1];
            best_xfer = xfer;
            best_pref = pr;
            have = 1'b1;
          end
        end
      end
    end

    // Load granted packets and advance the pointers.
    if (!have || best_xfer == 0) begin
      best[0] = NO_OUT;
      best[1] = NO_OUT;
    end else begin
      grant_count += best_xfer;
      for (i = 0; i < 2; i++) begin
        o = best[i];
        if (o != NO_OUT) begin
          ser_busy[o] = 1'b1;
          ser_left[o] = len[i];
          ser_tag[o] = hd[i].tag & rballoc_pkg::TAG_MASK;
          if (tie[i]) tie_dir = ~tie_dir;
        end
      end
      if (hd[0].valid && hd[1].valid && pref[0] == pref[1]) favored = ~favored;
    end

    // Serializer countdown; the packet leaves in its last tick.
    for (o = 0; o < 2; o++) begin
      hv[o] = 1'b0;
      htag[o] = '0;
      if (ser_busy[o]) begin
        if (ser_left[o] <= step) begin
          hv[o] = 1'b1;
          htag[o] = ser_tag[o];
          ser_left[o] = 0;
          ser_busy[o] = 1'b0;
          handoff_count++;
        end else begin
          ser_left[o] -= step;
        end
      end
    end

    r.dec.cw_grant = grant_code(best[0]);
    r.dec.ccw_grant = grant_code(best[1]);
    r.dec.favored = favored;
    r.cw.handoff_valid = hv[0];
    r.cw.handoff_tag = htag[0];
    r.cw.idle = !ser_busy[0];
    r.ccw.handoff_valid = hv[1];
    r.ccw.handoff_tag = htag[1];
    r.ccw.idle = !ser_busy[1];
    return r;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Sample both channels, predict accepted ticks and check accepted results.
  always @(posedge clk) begin
    rballoc_pkg::tick_t   seen;
    rballoc_pkg::result_t want;
    if (rst) begin
      tick_taken <= 1'b0;
      width_reg = rballoc_pkg::WIDTH_RESET;
      for (int k = 0; k < 2; k++) begin
        ser_left[k] = 0;
        ser_tag[k] = '0;
        ser_busy[k] = 1'b0;
      end
      favored = 1'b0;
      tie_dir = 1'b0;
    end else begin
      tick_taken <= tick_if.valid && tick_if.ready;
      if (tick_if.valid && tick_if.ready) begin
        seen.cw.valid = tick_if.cw_head_valid;
        seen.cw.tag = tick_if.cw_head_tag;
        seen.cw.bytes = tick_if.cw_head_bytes;
        seen.cw.pref = tick_if.cw_head_pref;
        seen.ccw.valid = tick_if.ccw_head_valid;
        seen.ccw.tag = tick_if.ccw_head_tag;
        seen.ccw.bytes = tick_if.ccw_head_bytes;
        seen.ccw.pref = tick_if.ccw_head_pref;
        seen.cw_space = tick_if.cw_out_space;
        seen.ccw_space = tick_if.ccw_out_space;
        expected_allocs = {expected_allocs, predict_tick(seen)};
        ticks_taken++;
      end
      if (alloc_if.valid && alloc_if.ready) begin
        if (expected_allocs.size() == 0) begin
          $error("allocation result arrived with none expected");
          fail_count++;
        end else begin
          want = expected_allocs.pop_front();
          results_checked++;
          compare_field("cw_head_grant", want.dec.cw_grant, alloc_if.cw_head_grant);
          compare_field("ccw_head_grant", want.dec.ccw_grant, alloc_if.ccw_head_grant);
          compare_field("cw_handoff_valid", want.cw.handoff_valid, alloc_if.cw_handoff_valid);
          compare_field("cw_handoff_tag", want.cw.handoff_tag, alloc_if.cw_handoff_tag);
          compare_field("ccw_handoff_valid", want.ccw.handoff_valid,
                        alloc_if.ccw_handoff_valid);
          compare_field("ccw_handoff_tag", want.ccw.handoff_tag, alloc_if.ccw_handoff_tag);
          compare_field("cw_out_idle", want.cw.idle, alloc_if.cw_out_idle);
          compare_field("ccw_out_idle", want.ccw.idle, alloc_if.ccw_out_idle);
          compare_field("round_robin_input", want.dec.favored, alloc_if.round_robin_input);
        end
      end
    end
  end

  // Drive ticks from the queue and the result ready, both on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      tick_if.valid <= 1'b0;
      alloc_if.ready <= 1'b0;
    end else begin
      alloc_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!tick_if.valid || tick_taken) begin
        if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_tick = tick_queue.pop_front();
          tick_if.valid <= 1'b1;
          tick_if.cw_head_valid <= drive_tick.cw.valid;
          tick_if.cw_head_tag <= drive_tick.cw.tag;
          tick_if.cw_head_bytes <= drive_tick.cw.bytes;
          tick_if.cw_head_pref <= drive_tick.cw.pref;
          tick_if.ccw_head_valid <= drive_tick.ccw.valid;
          tick_if.ccw_head_tag <= drive_tick.ccw.tag;
          tick_if.ccw_head_bytes <= drive_tick.ccw.bytes;
          tick_if.ccw_head_pref <= drive_tick.ccw.pref;
          tick_if.cw_out_space <= drive_tick.cw_space;
          tick_if.ccw_out_space <= drive_tick.ccw_space;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic rballoc_pkg::head_t mk_head(logic v, int tag, int len, logic [1:0] pref);
    rballoc_pkg::head_t h;
    h.valid = v;
    h.tag = rballoc_pkg::TAG_W'(tag);
    h.bytes = rballoc_pkg::BYTES_W'(len);
    h.pref = pref;
    return h;
  endfunction

  task automatic queue_tick(rballoc_pkg::head_t cw, rballoc_pkg::head_t ccw, logic cw_space,
                            logic ccw_space);
    rballoc_pkg::tick_t t;
    t.cw = cw;
    t.ccw = ccw;
    t.cw_space = cw_space;
    t.ccw_space = ccw_space;
    tick_queue = {tick_queue, t};
  endtask

  // Mostly short packets; a few zero, up-to-full-size and over-size lengths.
  function automatic int rand_len(int short_max, int rare_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < rare_pct) return 0;
    if (sel < 2 * rare_pct) return $urandom_range(257, 511);
    if (sel < 3 * rare_pct) return $urandom_range(1, rballoc_pkg::MAX_PACKET_BYTES);
    return $urandom_range(1, short_max);
  endfunction

  function automatic rballoc_pkg::head_t rand_head(int short_max, int rare_pct);
    return mk_head($urandom_range(0, 99) < 85, $urandom, rand_len(short_max, rare_pct),
                   2'($urandom_range(0, 3)));
  endfunction

  task automatic queue_random(int n, int short_max, int rare_pct);
    repeat (n) begin
      queue_tick(rand_head(short_max, rare_pct), rand_head(short_max, rare_pct),
                 $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85);
    end
  endtask

  // Wait until every tick has been driven and every result checked.
  task automatic wait_drained();
    while (tick_queue.size() != 0 || tick_if.valid || expected_allocs.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write the width register; only called while the allocator is idle.
  task automatic write_width(logic [rballoc_pkg::WIDTH_W-1:0] value);
    @(negedge clk);
    cfg_if.bytes_per_tick <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    width_reg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop a run that hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int w;
    tick_if.valid = 1'b0;
    tick_if.cw_head_valid = 1'b0;
    tick_if.cw_head_tag = '0;
    tick_if.cw_head_bytes = '0;
    tick_if.cw_head_pref = PREF_CW;
    tick_if.ccw_head_valid = 1'b0;
    tick_if.ccw_head_tag = '0;
    tick_if.ccw_head_bytes = '0;
    tick_if.ccw_head_pref = PREF_CW;
    tick_if.cw_out_space = 1'b0;
    tick_if.ccw_out_space = 1'b0;
    alloc_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.bytes_per_tick = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset width.
    // Invalid heads carrying junk fields.
    queue_tick(mk_head(0, 'hFFFF, 511, PREF_TIE_ALT), mk_head(0, 'hFFFF, 511, PREF_TIE_ALT),
               1, 1);
    queue_tick(mk_head(1, 'h0000, 1, PREF_CW), mk_head(0, 0, 0, PREF_CW), 1, 1);
    // Zero length behaves like one byte.
    queue_tick(mk_head(0, 0, 0, PREF_CW), mk_head(1, 'hFFFF, 0, PREF_CCW), 1, 1);
    // Both heads want the same output, twice, so the round-robin pointer flips.
    queue_tick(mk_head(1, 'h1111, 32, PREF_CW), mk_head(1, 'h2222, 32, PREF_CW), 1, 1);
    queue_tick(mk_head(1, 'h3333, 33, PREF_CCW), mk_head(1, 'h4444, 64, PREF_CCW), 1, 1);
    // Tie preferences, including the spare code.
    queue_tick(mk_head(1, 'h5555, 1, PREF_TIE), mk_head(1, 'h6666, 1, PREF_TIE), 1, 1);
    queue_tick(mk_head(1, 'h7777, 8, PREF_TIE_ALT), mk_head(1, 'h8888, 8, PREF_CW), 1, 1);
    // Destination space withheld.
    queue_tick(mk_head(1, 'h0101, 4, PREF_CW), mk_head(1, 'h0202, 4, PREF_CCW), 0, 0);
    queue_tick(mk_head(1, 'h0303, 4, PREF_CW), mk_head(1, 'h0404, 4, PREF_CCW), 1, 0);
    queue_tick(mk_head(1, 'h0505, 4, PREF_CW), mk_head(1, 'h0606, 4, PREF_CCW), 0, 1);
    // Crossed preferences, then one output without space.
    queue_tick(mk_head(1, 'h0707, 2, PREF_CCW), mk_head(1, 'h0808, 2, PREF_CW), 1, 1);
    queue_tick(mk_head(1, 'h0909, 2, PREF_CCW), mk_head(1, 'h0A0A, 2, PREF_CCW), 1, 0);
    // Full-size and over-size packets keep both serializers busy.
    queue_tick(mk_head(1, 'hAAAA, 256, PREF_CW), mk_head(1, 'h5555, 300, PREF_CCW), 1, 1);
    repeat (3) begin
      queue_tick(mk_head(1, 'h1234, 1, PREF_CW), mk_head(1, 'h4321, 1, PREF_CCW), 1, 1);
    end
    queue_tick(mk_head(0, 0, 1, PREF_CW), mk_head(0, 0, 1, PREF_CW), 0, 0);
    queue_tick(mk_head(1, 'hA5A5, 511, PREF_CCW), mk_head(1, 'h5A5A, 257, PREF_CW), 1, 1);
    queue_tick(mk_head(0, 0, 1, PREF_CW), mk_head(1, 'hBEEF, 5, PREF_TIE), 1, 1);
    wait_drained();

    // Narrowest width: mostly short packets.
    write_width(7'd1);
    queue_random(180, 4, 1);
    wait_drained();

    // Swap the idling of the two sides.
    send_idle_pct = 83;
    recv_idle_pct = 16;
    write_width(7'd64);
    queue_random(180, 200, 4);
    wait_drained();

    // Zero width counts as one byte per tick.
    write_width(7'd0);
    queue_random(180, 3, 1);
    wait_drained();

    // No idling on either side from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_width(7'd127);
    queue_random(180, 256, 5);
    wait_drained();

    w = $urandom_range(2, 64);
    write_width(7'(w));
    queue_random(180, 3 * w, 4);
    wait_drained();

    write_width(7'(w));
    queue_random(180, 2 * w, 3);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_allocs.size() != 0) begin
      $error("%0d allocation results never arrived", expected_allocs.size());
      fail_count++;
    end

    $display("Checked %0d results for %0d ticks across seven width settings, including 0 and 127.",
             results_checked, ticks_taken);
    $display("Predicted %0d grants and %0d handoffs; %0d mismatches.",
             grant_count, handoff_count, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
